// ----- hdl/tlr_pkg.sv -----
// Shared constants, codes and the step level table of the triangle LFO with rungler.
package tlr_pkg;

  localparam int unsigned PhaseWidth = 8;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned CfgIndexWidth = 1;

  localparam logic [PhaseWidth-1:0] SquareLimit = 8'd200;
  localparam logic [LevelWidth-1:0] FullLevel = 8'd255;

  typedef enum logic [1:0] {
    ModeKeep   = 2'd0,
    ModeInvert = 2'd1,
    ModeRandom = 2'd2,
    ModeSpare  = 2'd3
  } rungler_mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgMode = 1'd0,
    CfgSeed = 1'd1
  } cfg_index_e;

  function automatic logic [LevelWidth-1:0] step_level(input logic [2:0] idx);
    logic [LevelWidth-1:0] lvl;
    unique case (idx)
      3'd0: lvl = 8'd0;
      3'd1: lvl = 8'd80;
      3'd2: lvl = 8'd120;
      3'd3: lvl = 8'd150;
      3'd4: lvl = 8'd180;
      3'd5: lvl = 8'd200;
      3'd6: lvl = 8'd220;
      3'd7: lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

// ----- hdl/triangle_lfo_with_rungler_core.sv -----
// Top level of the triangle LFO with rungler: tick processing, state and result register.
// Every accepted request is one timer tick and yields exactly one result in the following cycle.
// The block takes one tick per clock cycle; all per-tick work is a short path from the
// state registers into a single result register, and a new tick is taken whenever that
// register is empty or its result is being taken in the same cycle. A write to the seed
// register loads the rungler shift register; writes are expected only while no tick is
// in flight.
module triangle_lfo_with_rungler_core
  import tlr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     reset_level_i,
  input  logic                     random_bit_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LevelWidth-1:0]    triangle_level_o,
  output logic [LevelWidth-1:0]    stepped_level_o,
  output logic                     square_out_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  logic [1:0]            mode_q;
  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic                  falling_q, falling_d;
  logic                  last_reset_q;
  logic [7:0]            rungler_q, rungler_d;
  logic [LevelWidth-1:0] held_step_q, held_step_d;
  logic                  out_valid_q;
  logic [LevelWidth-1:0] tri_q, tri_d;
  logic                  square_q, square_d;

  logic                  accept;
  logic                  reset_edge;
  logic                  wrap;
  logic                  fresh_bit;
  logic [PhaseWidth-1:0] phase_inc;
  logic                  falling_pre;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    phase_inc   = phase_q + 8'd1;
    square_d    = falling_q && (phase_inc < SquareLimit);
    reset_edge  = reset_level_i && !last_reset_q;
    phase_d     = reset_edge ? '0 : phase_inc;
    falling_pre = reset_edge ? 1'b0 : falling_q;
    wrap        = (phase_d == '0);
    falling_d   = wrap ? !falling_pre : falling_pre;
    case (rungler_mode_e'(mode_q))
      ModeInvert: fresh_bit = !rungler_q[7];
      ModeRandom: fresh_bit = random_bit_i;
      default:    fresh_bit = rungler_q[7];
    endcase
    rungler_d   = wrap ? {rungler_q[6:0], fresh_bit} : rungler_q;
    held_step_d = wrap ? step_level({rungler_d[5], rungler_d[3], rungler_d[0]})
                       : held_step_q;
    tri_d       = falling_d ? (FullLevel - phase_d) : phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeInvert;
      phase_q      <= '0;
      falling_q    <= 1'b0;
      last_reset_q <= 1'b0;
      rungler_q    <= '0;
      held_step_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        falling_q    <= falling_d;
        last_reset_q <= reset_level_i;
        rungler_q    <= rungler_d;
        held_step_q  <= held_step_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CfgMode: mode_q    <= cfg_data_i[1:0];
          CfgSeed: rungler_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tri_q    <= tri_d;
      square_q <= square_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign triangle_level_o = tri_q;
  assign stepped_level_o  = held_step_q;
  assign square_out_o     = square_q;

  // An accepted tick always leaves a result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> out_valid_o)
    else $error("Accepted request produced no result.");

  // A rising reset edge restarts the phase and leaves the flag set, so the level is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && reset_level_i && !last_reset_q |=> triangle_level_o == FullLevel)
    else $error("Reset edge did not restart the triangle at full level.");

  // The input side stalls only behind a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("Input stalled with no pending result.");

  // The stepped level only moves when the phase wraps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && !wrap |=> held_step_q == $past(held_step_q))
    else $error("Stepped level changed without a wrap.");

endmodule
